FILE: src/lpb_pkg.sv
// Shared types and constants for the LRU page buffer.
`default_nettype none
package lpb_pkg;

    localparam int KEY_W   = 32;
    localparam int CNT_W   = 32;
    localparam int CAP_W   = 5;
    localparam int M_DATA_W = 104;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FILL,
        ST_DONE
    } lpb_state_t;

endpackage
`default_nettype wire

FILE: src/lru_page_buffer.sv
// LRU page buffer: fully associative page directory kept in recency order.
//
// Input channel s_*: one 32-bit page key per word. Output channel m_*: one
// result word per key: hit flag, eviction flag and key, hit and miss totals.
// Capacity comes from cfg_we/cfg_wdata; the user must write it only while
// idle (the block does not enforce this). Zero acts as one, above MAX_PAGES
// as MAX_PAGES. Set below the occupancy, every miss evicts; occupancy stays.
//
// Keys and ranks share one synchronous memory (one read, one write port).
// One read pass compares every entry, a second read-modify-write pass ages
// the ranks and, on a miss with room left, a fill step writes the new key.
// One item is worked on at a time.
// The result sits in an output register; the next key is accepted while it
// waits. If the receiver stalls with a result still held, the following item
// finishes its work and then waits until the register frees.
// Reset empties the directory, clears both totals and sets capacity to 16.
// No clearing pass is needed: entries above the occupancy are never read.
`default_nettype none
module lru_page_buffer #(
    parameter int MAX_PAGES = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // page_key[31:0]
    input  wire logic [lpb_pkg::KEY_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // hit[0], evicted_valid[1], evicted_key[33:2], hits_so_far[65:34],
    // misses_so_far[97:66], zero[103:98]
    output logic [lpb_pkg::M_DATA_W-1:0]     m_tdata,
    input  wire logic                        cfg_we,
    input  wire logic [lpb_pkg::CAP_W-1:0]   cfg_wdata
);
    import lpb_pkg::*;

    localparam int RW = $clog2(MAX_PAGES);
    localparam int OW = $clog2(MAX_PAGES + 1);
    localparam int EW = 9;
    localparam int MW = KEY_W + RW;

    logic [MW-1:0] mem [MAX_PAGES];
    logic [MW-1:0] rd_data_reg;

    lpb_state_t state_reg, state_next;
    logic [OW-1:0]    cnt_reg, cnt_next;
    logic [OW-1:0]    occ_reg, occ_next;
    logic [CAP_W-1:0] cap_reg;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             found_reg, found_next;
    logic [RW-1:0]    found_idx_reg, found_idx_next;
    logic [RW-1:0]    found_rank_reg, found_rank_next;
    logic             vic_found_reg, vic_found_next;
    logic [RW-1:0]    vic_idx_reg, vic_idx_next;
    logic [KEY_W-1:0] vic_key_reg, vic_key_next;
    logic             evict_reg, evict_next;
    logic [CNT_W-1:0] hit_total_reg, hit_total_next;
    logic [CNT_W-1:0] miss_total_reg, miss_total_next;
    logic             m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic             mem_we;
    logic [RW-1:0]    mem_waddr;
    logic [MW-1:0]    mem_wdata;
    logic [RW-1:0]    mem_raddr;

    logic [EW-1:0]    cap_ext, eff_cap, occ_ext;
    logic             full;
    logic [OW-1:0]    occ_m1, cnt_m1;
    logic [RW-1:0]    oldest_rank, proc_idx, rd_rank, limit, new_rank, target_idx;
    logic [KEY_W-1:0] rd_key, new_key;
    logic             is_target, do_age;

    always_comb begin
        cap_ext = EW'(cap_reg);
        if (cap_ext == '0) begin
            eff_cap = EW'(1);
        end else if (cap_ext > EW'(MAX_PAGES)) begin
            eff_cap = EW'(MAX_PAGES);
        end else begin
            eff_cap = cap_ext;
        end
        occ_ext     = EW'(occ_reg);
        full        = (occ_ext >= eff_cap);
        occ_m1      = occ_reg - OW'(1);
        cnt_m1      = cnt_reg - OW'(1);
        oldest_rank = occ_m1[RW-1:0];
        proc_idx    = cnt_m1[RW-1:0];
        rd_key      = rd_data_reg[MW-1:RW];
        rd_rank     = rd_data_reg[RW-1:0];
        target_idx  = found_reg ? found_idx_reg : vic_idx_reg;
        limit       = found_reg ? found_rank_reg : oldest_rank;
        is_target   = (found_reg || full) && (proc_idx == target_idx);
        do_age      = (!found_reg && !full) || (rd_rank < limit);
        if (is_target) begin
            new_rank = '0;
        end else if (do_age) begin
            new_rank = rd_rank + RW'(1);
        end else begin
            new_rank = rd_rank;
        end
        new_key = (is_target && !found_reg) ? key_reg : rd_key;
    end

    assign mem_raddr = cnt_reg[RW-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        occ_next        = occ_reg;
        key_next        = key_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_rank_next = found_rank_reg;
        vic_found_next  = vic_found_reg;
        vic_idx_next    = vic_idx_reg;
        vic_key_next    = vic_key_reg;
        evict_next      = evict_reg;
        hit_total_next  = hit_total_reg;
        miss_total_next = miss_total_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = proc_idx;
        mem_wdata       = {new_key, new_rank};
        s_tready        = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    key_next       = s_tdata;
                    found_next     = 1'b0;
                    vic_found_next = 1'b0;
                    cnt_next       = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg != '0) begin
                    if (rd_key == key_reg && !found_reg) begin
                        found_next      = 1'b1;
                        found_idx_next  = proc_idx;
                        found_rank_next = rd_rank;
                    end
                    if (rd_rank == oldest_rank && !vic_found_reg) begin
                        vic_found_next = 1'b1;
                        vic_idx_next   = proc_idx;
                        vic_key_next   = rd_key;
                    end
                end
                if (cnt_reg == occ_reg) begin
                    cnt_next   = '0;
                    state_next = ST_UPDATE;
                end else begin
                    cnt_next = cnt_reg + OW'(1);
                end
            end
            ST_UPDATE: begin
                mem_we = (cnt_reg != '0);
                if (cnt_reg == occ_reg) begin
                    evict_next = !found_reg && full;
                    state_next = (!found_reg && !full) ? ST_FILL : ST_DONE;
                end else begin
                    cnt_next = cnt_reg + OW'(1);
                end
            end
            ST_FILL: begin
                mem_we     = 1'b1;
                mem_waddr  = occ_reg[RW-1:0];
                mem_wdata  = {key_reg, RW'(0)};
                occ_next   = occ_reg + OW'(1);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    if (found_reg) begin
                        if (hit_total_reg != '1) begin
                            hit_total_next = hit_total_reg + CNT_W'(1);
                        end
                    end else if (miss_total_reg != '1) begin
                        miss_total_next = miss_total_reg + CNT_W'(1);
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, miss_total_next, hit_total_next,
                                    evict_reg ? vic_key_reg : KEY_W'(0),
                                    evict_reg, found_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            occ_reg        <= '0;
            cap_reg        <= CAP_W'(16);
            hit_total_reg  <= '0;
            miss_total_reg <= '0;
            m_valid_reg    <= 1'b0;
            found_reg      <= 1'b0;
            vic_found_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            occ_reg        <= occ_next;
            hit_total_reg  <= hit_total_next;
            miss_total_reg <= miss_total_next;
            m_valid_reg    <= m_valid_next;
            found_reg      <= found_next;
            vic_found_reg  <= vic_found_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        found_idx_reg  <= found_idx_next;
        found_rank_reg <= found_rank_next;
        vic_idx_reg    <= vic_idx_next;
        vic_key_reg    <= vic_key_next;
        evict_reg      <= evict_next;
        m_data_reg     <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        EW'(occ_reg) <= EW'(MAX_PAGES))
        else $error("occupancy above directory size");

    a_fill_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FILL |-> !found_reg && !full)
        else $error("fill on hit or full directory");

    a_occ_changes_on_fill: assert property (@(posedge aclk)
        (aresetn && state_reg != ST_FILL) |=> (!aresetn || $stable(occ_reg)))
        else $error("occupancy changed outside fill");

    a_victim_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && !found_reg && full) |-> vic_found_reg)
        else $error("full miss without a victim");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("hit reported with eviction");

endmodule
`default_nettype wire
